### rtl/tpid_pkg.sv
// Shared constants, micro-op codes and status types of the two-axis PID position controller.
package tpid_pkg;

    localparam int STEPS_PER_MM_DEF = 5;
    localparam int NUM_AXES_DEF     = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 2'd3;

    localparam logic [CFG_DATA_W-1:0] PROP_GAIN_RST  = 16'd2048;
    localparam logic [CFG_DATA_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [CFG_DATA_W-1:0] DERIV_GAIN_RST = 16'd512;
    localparam logic [CFG_DATA_W-1:0] DEAD_BAND_RST  = 16'd512;

    localparam int MS_PER_S = 1000;

    localparam int DIV_NUM_W        = 64;
    localparam int DIV_DEN_W        = 16;
    localparam int DIV_BITS_PER_CYC = 4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_POS_START,
        OP_ERR,
        OP_TEST,
        OP_MUL_EMS,
        OP_INTEG,
        OP_MUL_IHI,
        OP_MUL_ILO,
        OP_I_FORM,
        OP_I_START,
        OP_I_WAIT,
        OP_DE,
        OP_MUL_D,
        OP_D_K,
        OP_D_START,
        OP_D_WAIT,
        OP_ABS,
        OP_MUL_SLO,
        OP_MUL_SHI,
        OP_SCALE,
        OP_GOAL,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic skip;
        logic ms_zero;
        logic div_done;
    } dp_status_t;

endpackage

### rtl/tpid_div.sv
// Iterative unsigned divider, four quotient bits per cycle.
module tpid_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [tpid_pkg::DIV_NUM_W-1:0] num,
    input  logic [tpid_pkg::DIV_DEN_W-1:0] den,
    output logic                           done,
    output logic [tpid_pkg::DIV_NUM_W-1:0] quo
);
    import tpid_pkg::*;

    localparam int STEPS = DIV_NUM_W / DIV_BITS_PER_CYC;
    localparam int CNT_W = $clog2(STEPS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W:0]   r_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] q_next;
    logic [DIV_DEN_W:0]   r_next;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
            r_next = {r_next[DIV_DEN_W-1:0], q_next[DIV_NUM_W-1]};
            q_next = {q_next[DIV_NUM_W-2:0], 1'b0};
            if (r_next >= {1'b0, den_reg}) begin
                r_next    = r_next - {1'b0, den_reg};
                q_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            r_reg   <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

### rtl/tpid_dp.sv
// Datapath: configuration registers, per-axis state, shared multiplier and divider.
module tpid_dp #(
    parameter int STEPS_PER_MM = tpid_pkg::STEPS_PER_MM_DEF,
    parameter int NUM_AXES     = tpid_pkg::NUM_AXES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tpid_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [tpid_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_axis_sel,
    input  logic signed [23:0]              s_target_mm,
    input  logic signed [23:0]              s_now_steps,
    input  logic [15:0]                     s_elapsed_ms,
    output logic                            m_axis_out,
    output logic signed [31:0]              m_goal_steps,
    output logic                            m_moved,
    output logic                            m_zero_dt,
    output logic                            m_clipped,
    input  tpid_pkg::op_t                   cmd,
    output tpid_pkg::dp_status_t            status
);
    import tpid_pkg::*;

    localparam int SLOTS = (NUM_AXES > 2) ? 2 : NUM_AXES;

    localparam logic signed [51:0] I48_HI = (52'sd1 <<< 47) - 52'sd1;
    localparam logic signed [51:0] I48_LO = -(52'sd1 <<< 47);
    localparam logic signed [33:0] E_HI   = 34'sd2147483647;
    localparam logic signed [33:0] E_LO   = -34'sd2147483648;
    localparam logic signed [63:0] G_HI   = 64'sd2147483647;
    localparam logic signed [63:0] G_LO   = -64'sd2147483648;

    logic [15:0]        kp_reg, ki_reg, kd_reg, db_reg;
    logic signed [47:0] integ_mem [SLOTS];
    logic signed [31:0] prev_mem  [SLOTS];

    logic               axis_reg;
    logic signed [23:0] tgt_reg;
    logic signed [23:0] now_reg;
    logic [15:0]        ms_reg;
    logic signed [31:0] err_reg;
    logic signed [47:0] integ_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] tmp_reg;
    logic signed [50:0] prod_reg;
    logic               dsign_reg, ssign_reg;
    logic               moved_reg, zdt_reg, clip_reg;
    logic signed [31:0] goal_reg;

    logic               out_axis_reg;
    logic signed [31:0] out_goal_reg;
    logic               out_moved_reg, out_zdt_reg, out_clip_reg;

    logic signed [16:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [50:0] mul_p;

    logic               axis_ok;
    logic signed [47:0] integ_rd;
    logic signed [31:0] prev_rd;
    logic signed [51:0] integ_sum;
    logic signed [47:0] integ_sat;
    logic               integ_hit;
    logic signed [33:0] pos_mag, pos, diff;
    logic signed [31:0] err_sat;
    logic signed [32:0] err_ext, err_mag;
    logic               skip_w;
    logic               div_start, div_done;
    logic signed [63:0] div_src;
    logic [63:0]        div_num, div_quo;
    logic [15:0]        div_den;
    logic signed [63:0] q_s;
    logic signed [63:0] dk, scale_mag, acc_abs, gsum;
    logic signed [31:0] goal_sat;
    logic               goal_hit;

    tpid_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            OP_MUL_EMS: begin
                mul_a = {1'b0, ms_reg};
                mul_b = 34'(err_reg);
            end
            OP_INTEG: begin
                mul_a = {1'b0, kp_reg};
                mul_b = 34'(err_reg);
            end
            OP_MUL_IHI: begin
                mul_a = {1'b0, ki_reg};
                mul_b = 34'($signed(integ_reg[47:24]));
            end
            OP_MUL_ILO: begin
                mul_a = {1'b0, ki_reg};
                mul_b = {10'b0, integ_reg[23:0]};
            end
            OP_MUL_D: begin
                mul_a = {1'b0, kd_reg};
                mul_b = $signed(tmp_reg[33:0]);
            end
            OP_MUL_SLO: begin
                mul_a = 17'(STEPS_PER_MM);
                mul_b = {2'b0, tmp_reg[31:0]};
            end
            OP_MUL_SHI: begin
                mul_a = 17'(STEPS_PER_MM);
                mul_b = {2'b0, tmp_reg[63:32]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 51'(mul_a) * 51'(mul_b);

    assign axis_ok  = int'(axis_reg) < NUM_AXES;
    assign integ_rd = integ_mem[axis_reg];
    assign prev_rd  = prev_mem[axis_reg];

    always_comb begin
        integ_sum = 52'(integ_rd) + 52'(prod_reg);
        integ_hit = 1'b0;
        if (integ_sum > I48_HI) begin
            integ_sat = 48'(I48_HI);
            integ_hit = 1'b1;
        end else if (integ_sum < I48_LO) begin
            integ_sat = 48'(I48_LO);
            integ_hit = 1'b1;
        end else begin
            integ_sat = 48'(integ_sum);
        end
    end

    always_comb begin
        pos_mag = $signed({1'b0, div_quo[32:0]});
        pos     = dsign_reg ? -pos_mag : pos_mag;
        diff    = 34'(tgt_reg) - pos;
        if (diff > E_HI) begin
            err_sat = 32'(E_HI);
        end else if (diff < E_LO) begin
            err_sat = 32'(E_LO);
        end else begin
            err_sat = 32'(diff);
        end
    end

    assign err_ext = 33'(err_reg);
    assign err_mag = (err_ext < 0) ? -err_ext : err_ext;
    assign skip_w  = !axis_ok || (err_mag <= $signed({17'b0, db_reg}));

    assign div_start = (cmd == OP_POS_START) || (cmd == OP_I_START) || (cmd == OP_D_START);
    assign div_src   = (cmd == OP_POS_START) ? (64'(now_reg) <<< 8) : tmp_reg;
    assign div_num   = div_src[63] ? $unsigned(-div_src) : $unsigned(div_src);

    always_comb begin
        case (cmd)
            OP_POS_START: div_den = 16'(STEPS_PER_MM);
            OP_I_START:   div_den = 16'(MS_PER_S);
            default:      div_den = ms_reg;
        endcase
    end

    assign q_s       = dsign_reg ? -$signed(div_quo) : $signed(div_quo);
    assign dk        = 64'(prod_reg);
    assign scale_mag = (64'(prod_reg) <<< 16) + (acc_reg >>> 16);
    assign acc_abs   = acc_reg[63] ? -acc_reg : acc_reg;

    always_comb begin
        gsum     = 64'(now_reg) + acc_reg;
        goal_hit = 1'b0;
        if (gsum > G_HI) begin
            goal_sat = 32'(G_HI);
            goal_hit = 1'b1;
        end else if (gsum < G_LO) begin
            goal_sat = 32'(G_LO);
            goal_hit = 1'b1;
        end else begin
            goal_sat = 32'(gsum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= PROP_GAIN_RST;
            ki_reg <= INTEG_GAIN_RST;
            kd_reg <= DERIV_GAIN_RST;
            db_reg <= DEAD_BAND_RST;
            for (int i = 0; i < SLOTS; i++) begin
                integ_mem[i] <= '0;
                prev_mem[i]  <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_PROP_GAIN:  kp_reg <= cfg_wdata;
                    REG_INTEG_GAIN: ki_reg <= cfg_wdata;
                    REG_DERIV_GAIN: kd_reg <= cfg_wdata;
                    REG_DEAD_BAND:  db_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd == OP_INTEG) begin
                integ_mem[axis_reg] <= integ_sat;
            end
            if (cmd == OP_DE) begin
                prev_mem[axis_reg] <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            dsign_reg <= div_src[63];
        end
        case (cmd)
            OP_LOAD: begin
                axis_reg <= s_axis_sel;
                tgt_reg  <= s_target_mm;
                now_reg  <= s_now_steps;
                ms_reg   <= s_elapsed_ms;
                clip_reg <= 1'b0;
            end
            OP_ERR: err_reg <= err_sat;
            OP_TEST: begin
                moved_reg <= !skip_w;
                zdt_reg   <= !skip_w && (ms_reg == '0);
                goal_reg  <= 32'(now_reg);
            end
            OP_MUL_EMS: prod_reg <= mul_p;
            OP_INTEG: begin
                integ_reg <= integ_sat;
                clip_reg  <= integ_hit;
                prod_reg  <= mul_p;
            end
            OP_MUL_IHI: begin
                acc_reg  <= 64'(prod_reg);
                prod_reg <= mul_p;
            end
            OP_MUL_ILO: begin
                tmp_reg  <= 64'(prod_reg) <<< 24;
                prod_reg <= mul_p;
            end
            OP_I_FORM: tmp_reg <= tmp_reg + 64'(prod_reg);
            OP_I_WAIT: begin
                if (div_done) begin
                    acc_reg <= acc_reg + q_s;
                end
            end
            OP_DE: tmp_reg <= 64'(err_reg) - 64'(prev_rd);
            OP_MUL_D: prod_reg <= mul_p;
            OP_D_K: tmp_reg <= (dk <<< 10) - (dk <<< 4) - (dk <<< 3);
            OP_D_WAIT: begin
                if (div_done) begin
                    acc_reg <= acc_reg + q_s;
                end
            end
            OP_ABS: begin
                tmp_reg   <= acc_abs;
                ssign_reg <= acc_reg[63];
            end
            OP_MUL_SLO: prod_reg <= mul_p;
            OP_MUL_SHI: begin
                acc_reg  <= 64'(prod_reg);
                prod_reg <= mul_p;
            end
            OP_SCALE: acc_reg <= ssign_reg ? -scale_mag : scale_mag;
            OP_GOAL: begin
                goal_reg <= goal_sat;
                clip_reg <= clip_reg | goal_hit;
            end
            OP_OUT: begin
                out_axis_reg  <= axis_reg;
                out_goal_reg  <= goal_reg;
                out_moved_reg <= moved_reg;
                out_zdt_reg   <= zdt_reg;
                out_clip_reg  <= clip_reg;
            end
            default: ;
        endcase
    end

    assign status.skip     = skip_w;
    assign status.ms_zero  = (ms_reg == '0);
    assign status.div_done = div_done;

    assign m_axis_out   = out_axis_reg;
    assign m_goal_steps = out_goal_reg;
    assign m_moved      = out_moved_reg;
    assign m_zero_dt    = out_zdt_reg;
    assign m_clipped    = out_clip_reg;

endmodule

### rtl/tpid_ctrl.sv
// Controller: sequences the datapath micro-ops and owns both channel handshakes.
module tpid_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  tpid_pkg::dp_status_t status,
    output tpid_pkg::op_t        cmd
);
    import tpid_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_POS,
        ST_POS_WAIT,
        ST_ERR,
        ST_TEST,
        ST_MUL_EMS,
        ST_INTEG,
        ST_MUL_IHI,
        ST_MUL_ILO,
        ST_I_FORM,
        ST_I_START,
        ST_I_WAIT,
        ST_DE,
        ST_MUL_D,
        ST_D_K,
        ST_D_START,
        ST_D_WAIT,
        ST_ABS,
        ST_MUL_SLO,
        ST_MUL_SHI,
        ST_SCALE,
        ST_GOAL,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = OP_NONE;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd        = OP_LOAD;
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                cmd        = OP_POS_START;
                state_next = ST_POS_WAIT;
            end
            ST_POS_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd        = OP_ERR;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                cmd        = OP_TEST;
                state_next = status.skip ? ST_FINISH : ST_MUL_EMS;
            end
            ST_MUL_EMS: begin
                cmd        = OP_MUL_EMS;
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                cmd        = OP_INTEG;
                state_next = ST_MUL_IHI;
            end
            ST_MUL_IHI: begin
                cmd        = OP_MUL_IHI;
                state_next = ST_MUL_ILO;
            end
            ST_MUL_ILO: begin
                cmd        = OP_MUL_ILO;
                state_next = ST_I_FORM;
            end
            ST_I_FORM: begin
                cmd        = OP_I_FORM;
                state_next = ST_I_START;
            end
            ST_I_START: begin
                cmd        = OP_I_START;
                state_next = ST_I_WAIT;
            end
            ST_I_WAIT: begin
                cmd = OP_I_WAIT;
                if (status.div_done) begin
                    state_next = ST_DE;
                end
            end
            ST_DE: begin
                cmd        = OP_DE;
                state_next = status.ms_zero ? ST_ABS : ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd        = OP_MUL_D;
                state_next = ST_D_K;
            end
            ST_D_K: begin
                cmd        = OP_D_K;
                state_next = ST_D_START;
            end
            ST_D_START: begin
                cmd        = OP_D_START;
                state_next = ST_D_WAIT;
            end
            ST_D_WAIT: begin
                cmd = OP_D_WAIT;
                if (status.div_done) begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                cmd        = OP_ABS;
                state_next = ST_MUL_SLO;
            end
            ST_MUL_SLO: begin
                cmd        = OP_MUL_SLO;
                state_next = ST_MUL_SHI;
            end
            ST_MUL_SHI: begin
                cmd        = OP_MUL_SHI;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd        = OP_SCALE;
                state_next = ST_GOAL;
            end
            ST_GOAL: begin
                cmd        = OP_GOAL;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd          = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/two_axis_pid_position_deadband.sv
// Top level of the two-axis PID position controller with deadband.
// An item runs the position divide; with a correction it also runs the integral and derivative
// divides, up to three on the shared radix-16 divider, and with elapsed_ms zero the derivative one
// is skipped. Inside the deadband or beyond NUM_AXES it goes from the test straight to the result.
// One item at a time: s_ready rises as the result is loaded, which waits while a beat is stalled.
// Synchronous active-low reset restores default gains and clears integrators and previous errors.
module two_axis_pid_position_deadband #(
    parameter int STEPS_PER_MM = tpid_pkg::STEPS_PER_MM_DEF,
    parameter int NUM_AXES     = tpid_pkg::NUM_AXES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tpid_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [tpid_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_axis_sel,
    input  logic signed [23:0]              s_target_mm,
    input  logic signed [23:0]              s_now_steps,
    input  logic [15:0]                     s_elapsed_ms,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_axis_out,
    output logic signed [31:0]              m_goal_steps,
    output logic                            m_moved,
    output logic                            m_zero_dt,
    output logic                            m_clipped
);
    import tpid_pkg::*;

    op_t        cmd;
    dp_status_t status;

    tpid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tpid_dp #(
        .STEPS_PER_MM (STEPS_PER_MM),
        .NUM_AXES     (NUM_AXES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_sel   (s_axis_sel),
        .s_target_mm  (s_target_mm),
        .s_now_steps  (s_now_steps),
        .s_elapsed_ms (s_elapsed_ms),
        .m_axis_out   (m_axis_out),
        .m_goal_steps (m_goal_steps),
        .m_moved      (m_moved),
        .m_zero_dt    (m_zero_dt),
        .m_clipped    (m_clipped),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

### rtl/tpid_check.sv
// Port-level assertions for the two-axis PID position controller, bound to the top level.
module tpid_check (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_axis_out,
    input logic signed [31:0] m_goal_steps,
    input logic               m_moved,
    input logic               m_zero_dt,
    input logic               m_clipped
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_goal_steps) && $stable(m_axis_out)
            && $stable(m_moved) && $stable(m_zero_dt) && $stable(m_clipped))
        else $error("result beat changed while stalled");

    // a beat without a correction carries no flags
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_moved |-> !m_zero_dt && !m_clipped)
        else $error("zero_dt or clipped set without a correction");

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    // reset drops any pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind two_axis_pid_position_deadband tpid_check u_check (.*);

### tb/sv/tb.sv
// Self-checking testbench for the two-axis PID position controller with deadband.
module tb;
    import tpid_pkg::*;

    localparam int     STEPS_PER_MM = STEPS_PER_MM_DEF;
    localparam int     NUM_AXES     = NUM_AXES_DEF;
    localparam int     SETTLE_CYCLES = 80;
    localparam int     PHASE_ITEMS   = 40;
    localparam longint I48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint I48_MIN = -I48_MAX - 1;
    localparam longint I32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint I32_MIN = -I32_MAX - 1;
    localparam longint T24_MAX = 64'sd8388607;
    localparam longint T24_MIN = -T24_MAX - 1;

    typedef struct packed {
        logic               axis;
        logic signed [31:0] goal;
        logic               moved;
        logic               zero_dt;
        logic               clipped;
    } pid_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_axis_sel;
    logic signed [23:0]    s_target_mm;
    logic signed [23:0]    s_now_steps;
    logic [15:0]           s_elapsed_ms;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_axis_out;
    logic signed [31:0]    m_goal_steps;
    logic                  m_moved;
    logic                  m_zero_dt;
    logic                  m_clipped;

    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] band;
    longint      integ_sum [NUM_AXES];
    int          last_err [NUM_AXES];

    pid_result_t goal_q[$];
    int          err_count;
    int          send_idle;
    int          recv_idle;
    int          hold_left;

    two_axis_pid_position_deadband #(
        .STEPS_PER_MM(STEPS_PER_MM),
        .NUM_AXES    (NUM_AXES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_axis_sel  (s_axis_sel),
        .s_target_mm (s_target_mm),
        .s_now_steps (s_now_steps),
        .s_elapsed_ms(s_elapsed_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_axis_out  (m_axis_out),
        .m_goal_steps(m_goal_steps),
        .m_moved     (m_moved),
        .m_zero_dt   (m_zero_dt),
        .m_clipped   (m_clipped)
    );

    always #10 aclk = ~aclk;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic pid_result_t pid_predict(input logic axis,
                                                input logic signed [23:0] tgt,
                                                input logic signed [23:0] now,
                                                input logic [15:0] ms);
        pid_result_t res;
        longint      pos, err, mag, raw, acc, p_term, i_term, d_term, total, q, r, steps, goal;
        res      = '0;
        res.axis = axis;
        goal     = longint'(now);
        if (int'(axis) < NUM_AXES) begin
            pos = (longint'(now) * 256) / STEPS_PER_MM;
            err = clamp(longint'(tgt) - pos, I32_MIN, I32_MAX);
            mag = (err < 0) ? -err : err;
            if (mag > longint'(band)) begin
                res.moved = 1'b1;
                raw = integ_sum[axis] + err * longint'(ms);
                acc = clamp(raw, I48_MIN, I48_MAX);
                if (acc != raw) begin
                    res.clipped = 1'b1;
                end
                integ_sum[axis] = acc;
                p_term = longint'(gain_p) * err;
                i_term = (longint'(gain_i) * acc) / 1000;
                if (ms == 16'd0) begin
                    d_term      = 0;
                    res.zero_dt = 1'b1;
                end else begin
                    d_term = (longint'(gain_d) * (err - longint'(last_err[axis])) * 1000)
                             / longint'(ms);
                end
                last_err[axis] = int'(err);
                total = p_term + i_term + d_term;
                q     = total / 65536;
                r     = total % 65536;
                steps = q * STEPS_PER_MM + (r * STEPS_PER_MM) / 65536;
                raw   = longint'(now) + steps;
                goal  = clamp(raw, I32_MIN, I32_MAX);
                if (goal != raw) begin
                    res.clipped = 1'b1;
                end
            end
        end
        res.goal = goal[31:0];
        return res;
    endfunction

    task automatic send_item(input logic axis, input logic signed [23:0] tgt,
                             input logic signed [23:0] now, input logic [15:0] ms);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_axis_sel   <= axis;
        s_target_mm  <= tgt;
        s_now_steps  <= now;
        s_elapsed_ms <= ms;
        @(posedge aclk);
        while (s_ready !== 1'b1) begin
            @(posedge aclk);
        end
        goal_q.push_back(pid_predict(axis, tgt, now, ms));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (goal_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_gains(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [15:0] db);
        wait_drained();
        cfg_write(REG_PROP_GAIN, kp);
        cfg_write(REG_INTEG_GAIN, ki);
        cfg_write(REG_DERIV_GAIN, kd);
        cfg_write(REG_DEAD_BAND, db);
        cfg_wr_en <= 1'b0;
        gain_p = kp;
        gain_i = ki;
        gain_d = kd;
        band   = db;
    endtask

    task automatic send_random_item();
        logic               axis;
        logic signed [23:0] tgt;
        logic signed [23:0] now;
        logic [15:0]        ms;
        longint             pos, e, span, t;
        int                 pick;
        axis = 1'($urandom_range(0, 1));
        if ($urandom_range(99) < 70) begin
            now = 24'(int'($urandom_range(0, 320000)) - 160000);
            pos = (longint'(now) * 256) / STEPS_PER_MM;
            case ($urandom_range(0, 2))
                0: begin
                    span = 2 * longint'(band) + 4;
                end
                1: begin
                    span = longint'(1) << 20;
                end
                default: begin
                    span = longint'(1) << 23;
                end
            endcase
            e    = longint'($urandom_range(0, 32'(2 * span))) - span;
            t    = clamp(pos + e, T24_MIN, T24_MAX);
            tgt  = t[23:0];
            pick = $urandom_range(99);
            if (pick < 6) begin
                ms = 16'd0;
            end else if (pick < 90) begin
                ms = 16'($urandom_range(1, 50));
            end else begin
                ms = 16'($urandom_range(0, 65535));
            end
        end else begin
            tgt = 24'($urandom);
            now = 24'($urandom);
            ms  = 16'($urandom);
        end
        send_item(axis, tgt, now, ms);
    endtask

    task automatic test_deadband_edges();
        send_idle = 0;
        recv_idle = 0;
        send_item(1'b0, 24'sd0, 24'sd0, 16'd10);
        send_item(1'b1, 24'sd512, 24'sd0, 16'd10);
        send_item(1'b1, 24'sd513, 24'sd0, 16'd10);
        send_item(1'b0, -24'sd513, 24'sd0, 16'd10);
        send_item(1'b0, 24'sd5000, 24'sd5, 16'd0);
        send_item(1'b1, 24'sd1000, -24'sd3, 16'd7);
        send_item(1'b1, 24'sh7FFFFF, 24'sh800000, 16'hFFFF);
        send_item(1'b0, 24'sh800000, 24'sh7FFFFF, 16'hFFFF);
        send_item(1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 16'd1);
        send_item(1'b0, 24'sh800000, 24'sh800000, 16'd0);
        wait_drained();
    endtask

    task automatic test_integral_saturation();
        set_gains(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        repeat (6) send_item(1'b0, 24'sh800000, 24'sh7FFFFF, 16'hFFFF);
        repeat (6) send_item(1'b1, 24'sh7FFFFF, 24'sh800000, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_gains(PROP_GAIN_RST, 16'd300, DERIV_GAIN_RST, DEAD_BAND_RST);
        send_idle = 0;
        recv_idle = 0;
        hold_left = 400;
        repeat (8) send_random_item();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int s = 0; s < 6; s++) begin
            case (s)
                0: begin
                    set_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, DEAD_BAND_RST);
                end
                1: begin
                    set_gains(16'd0, 16'd0, 16'd0, 16'd0);
                end
                2: begin
                    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                end
                3: begin
                    set_gains(16'($urandom), 16'($urandom_range(0, 255)), 16'($urandom),
                              16'hFFFF);
                end
                default: begin
                    set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                end
            endcase
            for (int ph = 0; ph < 4; ph++) begin
                case (ph)
                    0: begin
                        send_idle = 0;
                        recv_idle = 0;
                    end
                    1: begin
                        send_idle = 67;
                        recv_idle = 0;
                    end
                    2: begin
                        send_idle = 0;
                        recv_idle = 67;
                    end
                    default: begin
                        send_idle = 22;
                        recv_idle = 22;
                    end
                endcase
                repeat (PHASE_ITEMS) send_random_item();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin : check_result
        pid_result_t want;
        pid_result_t got;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            got = {m_axis_out, m_goal_steps, m_moved, m_zero_dt, m_clipped};
            if (goal_q.size() == 0) begin
                $display("%0t: unexpected beat axis %0d goal %0d moved %0b zero_dt %0b clipped %0b",
                         $time, got.axis, got.goal, got.moved, got.zero_dt, got.clipped);
                err_count++;
            end else begin
                want = goal_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected axis %0d goal %0d moved %0b zero_dt %0b clipped %0b",
                             $time, want.axis, want.goal, want.moved, want.zero_dt,
                             want.clipped);
                    $display("%0t:          actual axis %0d goal %0d moved %0b zero_dt %0b clipped %0b",
                             $time, got.axis, got.goal, got.moved, got.zero_dt, got.clipped);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_axis_sel   = 1'b0;
        s_target_mm  = '0;
        s_now_steps  = '0;
        s_elapsed_ms = '0;
        m_ready      = 1'b0;
        err_count    = 0;
        send_idle    = 0;
        recv_idle    = 0;
        hold_left    = 0;
        gain_p       = PROP_GAIN_RST;
        gain_i       = INTEG_GAIN_RST;
        gain_d       = DERIV_GAIN_RST;
        band         = DEAD_BAND_RST;
        for (int a = 0; a < NUM_AXES; a++) begin
            integ_sum[a] = 0;
            last_err[a]  = 0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_deadband_edges();
        test_integral_saturation();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
